FILE: src/tma_pkg.sv
// Shared types and constants for the trimmed moving average filter.
// Depends on nothing; every other file in src imports it.
package tma_pkg;

  // Window length and sample width of the filter.
  localparam int WINDOW       = 15;
  localparam int SAMPLE_WIDTH = 16;

  // The divisor counts the samples left after the minimum and maximum are dropped.
  localparam int DIVISOR = WINDOW - 2;

  // The running sum carries one guard bit beyond the growth of the window.
  localparam int SUM_W = SAMPLE_WIDTH + $clog2(WINDOW) + 1;

  // Reduction tree geometry: leaves padded up to a power of two.
  localparam int LEVELS = $clog2(WINDOW);
  localparam int LEAVES = 1 << LEVELS;

  // Reciprocal for the constant divide. Rounding the reciprocal up with
  // log2(divisor) extra fraction bits makes the truncated product exact
  // for every magnitude below 2**SUM_W.
  localparam int DIV_SHIFT = SUM_W + $clog2(DIVISOR);
  localparam longint unsigned RECIP =
    ((64'd1 << DIV_SHIFT) + longint'(DIVISOR) - 64'd1) / longint'(DIVISOR);
  localparam int RECIP_W = DIV_SHIFT - $clog2(DIVISOR) + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam int QUOT_W  = PROD_W - DIV_SHIFT;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef sample_t window_t [WINDOW];

  // Sum, minimum and maximum of the window, passed to the divider.
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    sample_t                 lo;
    sample_t                 hi;
  } reduce_t;

endpackage

FILE: src/tma_reduce.sv
// Registered-free reduction tree: sum, minimum and maximum of the window.
// Depends on tma_pkg for the window type and tree geometry.
module tma_reduce (
  input  tma_pkg::window_t win,
  output tma_pkg::reduce_t red
);
  import tma_pkg::*;

  logic signed [SUM_W-1:0] sum_lvl [LEVELS+1][LEAVES];
  sample_t                 lo_lvl  [LEVELS+1][LEAVES];
  sample_t                 hi_lvl  [LEVELS+1][LEAVES];

  // Pairwise tree; padding leaves add zero and repeat the newest sample
  // so that they never change the minimum or the maximum.
  always_comb begin
    for (int l = 0; l <= LEVELS; l++) begin
      for (int i = 0; i < LEAVES; i++) begin
        sum_lvl[l][i] = '0;
        lo_lvl[l][i]  = win[0];
        hi_lvl[l][i]  = win[0];
      end
    end
    for (int i = 0; i < WINDOW; i++) begin
      sum_lvl[0][i] = SUM_W'(win[i]);
      lo_lvl[0][i]  = win[i];
      hi_lvl[0][i]  = win[i];
    end
    for (int l = 0; l < LEVELS; l++) begin
      for (int i = 0; i < (LEAVES >> (l + 1)); i++) begin
        sum_lvl[l+1][i] = sum_lvl[l][2*i] + sum_lvl[l][2*i+1];
        lo_lvl[l+1][i]  = (lo_lvl[l][2*i+1] < lo_lvl[l][2*i]) ?
                          lo_lvl[l][2*i+1] : lo_lvl[l][2*i];
        hi_lvl[l+1][i]  = (hi_lvl[l][2*i+1] > hi_lvl[l][2*i]) ?
                          hi_lvl[l][2*i+1] : hi_lvl[l][2*i];
      end
    end
  end

  assign red.sum = sum_lvl[LEVELS][0];
  assign red.lo  = lo_lvl[LEVELS][0];
  assign red.hi  = hi_lvl[LEVELS][0];

endmodule

FILE: src/tma_div.sv
// Trims the extremes from the window sum and divides by the constant divisor.
// Depends on tma_pkg for the reduction struct and reciprocal constants.
module tma_div (
  input  tma_pkg::reduce_t red,
  output tma_pkg::sample_t average
);
  import tma_pkg::*;

  logic signed [SUM_W-1:0]  trimmed;
  logic                     neg;
  logic        [SUM_W-1:0]  mag;
  logic        [PROD_W-1:0] prod;
  logic        [QUOT_W-1:0] quot;
  logic        [QUOT_W:0]   signed_quot;

  // Drop one copy of the minimum and one of the maximum.
  assign trimmed = red.sum - SUM_W'(red.lo) - SUM_W'(red.hi);

  // Divide the magnitude so the quotient truncates toward zero.
  assign neg  = trimmed[SUM_W-1];
  assign mag  = neg ? SUM_W'(-trimmed) : SUM_W'(trimmed);
  assign prod = PROD_W'(mag) * PROD_W'(RECIP);
  assign quot = prod[PROD_W-1:DIV_SHIFT];

  // Restore the sign; the mean lies within the sample range.
  assign signed_quot = neg ? -{1'b0, quot} : {1'b0, quot};
  assign average     = signed_quot[SAMPLE_WIDTH-1:0];

endmodule

FILE: src/trimmed_moving_average_filter.sv
// Trimmed moving average: the average of a request appears at the clock
// edge that accepts its sample. Throughput is one
// request per cycle, set by the single output register; input stalls only
// while that register is full and stalled. Synchronous reset clears the
// window to zeros and empties the output register at once.
module trimmed_moving_average_filter (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  sample_valid,
  output logic                                  sample_stall,
  input  logic signed [tma_pkg::SAMPLE_WIDTH-1:0] sample,
  output logic                                  average_valid,
  input  logic                                  average_stall,
  output logic signed [tma_pkg::SAMPLE_WIDTH-1:0] average
);
  import tma_pkg::*;

  window_t window;
  window_t window_next;
  reduce_t red;
  sample_t average_next;
  logic    accept;

  // The output register is free unless it holds a stalled result.
  assign sample_stall = average_valid && average_stall;
  assign accept       = sample_valid && !sample_stall;

  // Window as it stands once the new sample is shifted in.
  always_comb begin
    window_next[0] = sample;
    for (int k = 1; k < WINDOW; k++) begin
      window_next[k] = window[k-1];
    end
  end

  tma_reduce u_reduce (
    .win (window_next),
    .red (red)
  );

  tma_div u_div (
    .red     (red),
    .average (average_next)
  );

  // Window shift and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < WINDOW; k++) begin
        window[k] <= '0;
      end
      average_valid <= 1'b0;
    end else begin
      if (accept) begin
        window        <= window_next;
        average       <= average_next;
        average_valid <= 1'b1;
      end else if (!average_stall) begin
        average_valid <= 1'b0;
      end
    end
  end

  // An accepted request always produces a result in the next cycle.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> average_valid)
    else $error("accepted sample did not produce an average");

  // The newest window entry is the sample that was just accepted.
  a_window_head: assert property (@(posedge clk) disable iff (rst)
    accept |=> (window[0] == $past(sample)))
    else $error("window head does not hold the accepted sample");

  // The trimmed mean stays between the window's minimum and maximum.
  a_mean_in_range: assert property (@(posedge clk) disable iff (rst)
    accept |=> ((average >= $past(red.lo)) && (average <= $past(red.hi))))
    else $error("average outside the window range");

  // With no result pending, the block never holds off a new sample.
  a_idle_accepts: assert property (@(posedge clk) disable iff (rst)
    !average_valid |-> !sample_stall)
    else $error("input stalled while output register is empty");

  // Reset leaves the output register empty.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !average_valid)
    else $error("output valid after reset");

endmodule
